// File: rtl/fbba_pkg.sv
// Shared types and constants for the free-block bitmap allocator.
// Holds command and register codes, field widths and reset values.
// No dependencies; fbba_word_unit and the top level reference it by scoped names.
`default_nettype none

package fbba_pkg;

	// Field widths of the request, result and register channels.
	localparam int CMD_W        = 2;
	localparam int BLOCK_W      = 16;
	localparam int RSV_W        = 10;
	localparam int INIT_CNT_W   = 11;
	localparam int CFG_IDX_W    = 3;
	localparam int CFG_DATA_W   = 11;
	localparam int FREE_BLOCK_W = 10;
	localparam int FREE_TOTAL_W = 11;

	// Commands carried in a request.
	typedef enum logic [CMD_W-1:0] {
		CMD_INIT    = 2'd0,
		CMD_FIND    = 2'd1,
		CMD_DIRTY   = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_RSV_A    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RSV_B    = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RSV_C    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_RSV_D    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_INIT_CNT = 3'd4;

	// Register reset values.
	localparam logic [RSV_W-1:0]      RSV_A_RST    = 10'd0;
	localparam logic [RSV_W-1:0]      RSV_B_RST    = 10'd1;
	localparam logic [RSV_W-1:0]      RSV_C_RST    = 10'd2;
	localparam logic [RSV_W-1:0]      RSV_D_RST    = 10'd3;
	localparam logic [INIT_CNT_W-1:0] INIT_CNT_RST = 11'd1019;

	// Operation applied by the word unit to one bitmap bit.
	typedef enum logic {
		OP_CLEAR = 1'b0,
		OP_SET   = 1'b1
	} bit_op_t;

endpackage

`default_nettype wire

// File: rtl/fbba_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Used for the free-block bitmap; no package dependency.
`default_nettype none

module fbba_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                                    clk,
	input  wire logic                                    we,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                        wdata,
	input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// File: rtl/fbba_div.sv
// Block index split into bitmap word and bit position by a reciprocal multiply.
// One registered product, then a single correction step; no package dependency.
`default_nettype none

module fbba_div #(
	parameter int WORD_BITS = 32
) (
	input  wire logic                         clk,
	input  wire logic [15:0]                  idx,
	output logic      [15:0]                  quo,
	output logic      [$clog2(WORD_BITS)-1:0] rem
);

	localparam int SHIFT = 24;
	localparam int RECIP = (1 << SHIFT) / WORD_BITS;
	localparam int RW    = $clog2(RECIP + 1);
	localparam int PW    = 16 + RW;
	localparam int BW    = $clog2(WORD_BITS);

	logic [PW-1:0] prod_s1;
	logic [15:0]   idx_s1;
	logic [15:0]   q_est;
	logic [16:0]   r_est;
	logic [16:0]   r_fix;
	logic          over;

	// The estimate is low by at most one, since the index stays below 2^16.
	always_ff @(posedge clk) begin
		prod_s1 <= PW'(idx) * PW'(RECIP);
		idx_s1  <= idx;
	end

	// Remainder of the estimate, then one compare and subtract.
	always_comb begin
		q_est = 16'(prod_s1 >> SHIFT);
		r_est = 17'(idx_s1) - 17'(32'(q_est) * 32'(WORD_BITS));
		over  = (r_est >= 17'(WORD_BITS));
		r_fix = over ? (r_est - 17'(WORD_BITS)) : r_est;
	end

	assign quo = over ? (q_est + 16'd1) : q_est;
	assign rem = BW'(r_fix);

endmodule

`default_nettype wire

// File: rtl/fbba_word_unit.sv
// Shared word unit: finds the lowest set bit of a bitmap word and sets or
// clears one bit of it. Uses fbba_pkg for the bit operation code.
`default_nettype none

module fbba_word_unit #(
	parameter int WORD_BITS = 32
) (
	input  wire logic [WORD_BITS-1:0]         word_in,
	input  wire logic [$clog2(WORD_BITS)-1:0] bit_sel,
	input  wire fbba_pkg::bit_op_t            op,
	output logic      [WORD_BITS-1:0]         word_out,
	output logic                              hit,
	output logic      [$clog2(WORD_BITS)-1:0] pos
);

	localparam int BW = $clog2(WORD_BITS);

	logic [WORD_BITS-1:0] bit_mask;

	// Read-modify-write of a single bit.
	always_comb begin
		bit_mask = {{(WORD_BITS-1){1'b0}}, 1'b1} << bit_sel;
		if (op == fbba_pkg::OP_SET) begin
			word_out = word_in | bit_mask;
		end else begin
			word_out = word_in & ~bit_mask;
		end
	end

	// Priority search from the top so that the lowest set bit wins.
	always_comb begin
		pos = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (word_in[i]) begin
				pos = BW'(i);
			end
		end
		hit = |word_in;
	end

endmodule

`default_nettype wire

// File: rtl/free_block_bitmap_allocator.sv
// Top level of the free-block bitmap allocator: sequencer, registers, result.
// Depends on fbba_pkg, fbba_ram, fbba_div and fbba_word_unit.
//
//  channel | signals                                   | direction
//  --------+-------------------------------------------+----------
//  request | req_valid, req_stall, cmd, block          | in
//  result  | rsp_valid, rsp_stall, found, free_block,  | out
//          | free_total, status                        |
//  config  | cfg_valid, cfg_ready, cfg_index, cfg_data | in
//
// A find reads one bitmap word per cycle through the single RAM read port until a
// set bit or the last word; init refills the bitmap, then clears the bit of each
// in-range reserved block; mark dirty and release run a multiply, a read and a
// write; an out-of-range index skips the bitmap. After reset a fill pass sets the
// bitmap before the first request is taken.
// A stalled result holds off the next request.
`default_nettype none

module free_block_bitmap_allocator #(
	parameter int NUM_BLOCKS    = 1024,
	parameter int MAP_WORD_BITS = 32
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	// Request channel.
	input  wire logic                              req_valid,
	output logic                                   req_stall,
	input  wire logic [fbba_pkg::CMD_W-1:0]        cmd,
	input  wire logic [fbba_pkg::BLOCK_W-1:0]      block,
	// Result channel.
	output logic                                   rsp_valid,
	input  wire logic                              rsp_stall,
	output logic                                   found,
	output logic [fbba_pkg::FREE_BLOCK_W-1:0]      free_block,
	output logic [fbba_pkg::FREE_TOTAL_W-1:0]      free_total,
	output logic                                   status,
	// Configuration channel.
	input  wire logic                              cfg_valid,
	output logic                                   cfg_ready,
	input  wire logic [fbba_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [fbba_pkg::CFG_DATA_W-1:0]   cfg_data
);

	localparam int MAP_WORDS = (NUM_BLOCKS + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int BW        = $clog2(MAP_WORD_BITS);
	localparam int CW        = $clog2(NUM_BLOCKS + 1);
	localparam int LAST_BITS = NUM_BLOCKS - (MAP_WORDS - 1) * MAP_WORD_BITS;
	localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);
	localparam logic [MAP_WORD_BITS-1:0] LAST_MASK =
		{MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - LAST_BITS);
	localparam int RST_CNT = (int'(fbba_pkg::INIT_CNT_RST) > NUM_BLOCKS) ?
		NUM_BLOCKS : int'(fbba_pkg::INIT_CNT_RST);

	typedef enum logic [2:0] {
		ST_FILL,
		ST_IDLE,
		ST_RSV,
		ST_FIX,
		ST_RMW,
		ST_SCAN
	} state_t;

	state_t                          state_q;
	fbba_pkg::cmd_t                  cmd_q;
	logic [AW-1:0]                   wcnt_q;
	logic [AW-1:0]                   pend_s1;
	logic [1:0]                      sel_q;
	logic [AW-1:0]                   word_q;
	logic [BW-1:0]                   bit_q;
	logic [CW-1:0]                   count_q;
	logic [fbba_pkg::RSV_W-1:0]      rsv_a_q;
	logic [fbba_pkg::RSV_W-1:0]      rsv_b_q;
	logic [fbba_pkg::RSV_W-1:0]      rsv_c_q;
	logic [fbba_pkg::RSV_W-1:0]      rsv_d_q;
	logic [fbba_pkg::INIT_CNT_W-1:0] init_cnt_q;
	logic                            rsp_valid_q;
	logic                            found_q;
	logic [fbba_pkg::FREE_BLOCK_W-1:0] fblk_q;
	logic                            status_q;

	logic                            req_take;
	logic                            rsp_set;
	logic                            blk_ok;
	logic [fbba_pkg::RSV_W-1:0]      rsv_cur;
	logic                            rsv_ok;
	logic [15:0]                     div_idx;
	logic [15:0]                     quo;
	logic [BW-1:0]                   rem;
	logic                            ram_we;
	logic [AW-1:0]                   ram_waddr;
	logic [MAP_WORD_BITS-1:0]        ram_wdata;
	logic [AW-1:0]                   ram_raddr;
	logic [MAP_WORD_BITS-1:0]        ram_rdata;
	logic [MAP_WORD_BITS-1:0]        fill_word;
	logic [MAP_WORD_BITS-1:0]        wu_word_out;
	logic                            wu_hit;
	logic [BW-1:0]                   wu_pos;
	fbba_pkg::bit_op_t               wu_op;
	logic [AW-1:0]                   wcnt_inc;
	logic [AW-1:0]                   scan_start;
	logic [CW-1:0]                   count_inc;
	logic [CW-1:0]                   init_count;
	logic [31:0]                     find_idx;

	// Handshakes: a request is taken only when idle and the result slot frees.
	assign req_take  = req_valid && !req_stall;
	assign req_stall = !((state_q == ST_IDLE) && (!rsp_valid_q || !rsp_stall));
	assign cfg_ready = 1'b1;

	// Range checks and the reserved block under work.
	always_comb begin
		blk_ok = (32'(block) < 32'(NUM_BLOCKS));
		case (sel_q)
			2'd0:    rsv_cur = rsv_a_q;
			2'd1:    rsv_cur = rsv_b_q;
			2'd2:    rsv_cur = rsv_c_q;
			default: rsv_cur = rsv_d_q;
		endcase
		rsv_ok = (32'(rsv_cur) < 32'(NUM_BLOCKS));
	end

	// Counter helpers and the count loaded by init.
	always_comb begin
		wcnt_inc   = (wcnt_q == LAST_W) ? wcnt_q : (wcnt_q + AW'(1));
		scan_start = (LAST_W == '0) ? '0 : AW'(1);
		count_inc  = (32'(count_q) < 32'(NUM_BLOCKS)) ? (count_q + CW'(1)) : count_q;
		init_count = (32'(init_cnt_q) > 32'(NUM_BLOCKS)) ?
			CW'(NUM_BLOCKS) : CW'(init_cnt_q);
		fill_word  = (wcnt_q == LAST_W) ? LAST_MASK : {MAP_WORD_BITS{1'b1}};
		find_idx   = 32'(pend_s1) * 32'(MAP_WORD_BITS) + 32'(wu_pos);
	end

	// A result is loaded in the cycle where the sequencer finishes a request.
	always_comb begin
		case (state_q)
			ST_IDLE: rsp_set = req_take && !blk_ok &&
				(cmd inside {fbba_pkg::CMD_DIRTY, fbba_pkg::CMD_RELEASE});
			ST_RSV:  rsp_set = !rsv_ok && (sel_q == 2'd3);
			ST_RMW:  rsp_set = (cmd_q != fbba_pkg::CMD_INIT) || (sel_q == 2'd3);
			ST_SCAN: rsp_set = wu_hit || (pend_s1 == LAST_W);
			default: rsp_set = 1'b0;
		endcase
	end

	// Divider input: the request index when idle, a reserved block otherwise.
	assign div_idx = (state_q == ST_IDLE) ? block : 16'(rsv_cur);

	fbba_div #(
		.WORD_BITS (MAP_WORD_BITS)
	) u_div (
		.clk (clk),
		.idx (div_idx),
		.quo (quo),
		.rem (rem)
	);

	// RAM port selection for the fill sweep, bit updates and the scan.
	always_comb begin
		ram_we    = (state_q == ST_FILL) || (state_q == ST_RMW);
		ram_waddr = (state_q == ST_FILL) ? wcnt_q : word_q;
		ram_wdata = (state_q == ST_FILL) ? fill_word : wu_word_out;
		case (state_q)
			ST_FIX:  ram_raddr = AW'(quo);
			ST_SCAN: ram_raddr = wcnt_q;
			default: ram_raddr = '0;
		endcase
		wu_op = (cmd_q == fbba_pkg::CMD_RELEASE) ? fbba_pkg::OP_SET : fbba_pkg::OP_CLEAR;
	end

	fbba_ram #(
		.WIDTH (MAP_WORD_BITS),
		.DEPTH (MAP_WORDS)
	) u_map (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	fbba_word_unit #(
		.WORD_BITS (MAP_WORD_BITS)
	) u_word (
		.word_in  (ram_rdata),
		.bit_sel  (bit_q),
		.op       (wu_op),
		.word_out (wu_word_out),
		.hit      (wu_hit),
		.pos      (wu_pos)
	);

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsv_a_q    <= fbba_pkg::RSV_A_RST;
			rsv_b_q    <= fbba_pkg::RSV_B_RST;
			rsv_c_q    <= fbba_pkg::RSV_C_RST;
			rsv_d_q    <= fbba_pkg::RSV_D_RST;
			init_cnt_q <= fbba_pkg::INIT_CNT_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				fbba_pkg::REG_RSV_A:    rsv_a_q    <= cfg_data[fbba_pkg::RSV_W-1:0];
				fbba_pkg::REG_RSV_B:    rsv_b_q    <= cfg_data[fbba_pkg::RSV_W-1:0];
				fbba_pkg::REG_RSV_C:    rsv_c_q    <= cfg_data[fbba_pkg::RSV_W-1:0];
				fbba_pkg::REG_RSV_D:    rsv_d_q    <= cfg_data[fbba_pkg::RSV_W-1:0];
				fbba_pkg::REG_INIT_CNT: init_cnt_q <= cfg_data[fbba_pkg::INIT_CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer with the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			cmd_q       <= fbba_pkg::CMD_FIND;
			wcnt_q      <= '0;
			sel_q       <= '0;
			count_q     <= CW'(RST_CNT);
			rsp_valid_q <= 1'b0;
			found_q     <= 1'b0;
			fblk_q      <= '0;
			status_q    <= 1'b0;
			pend_s1     <= '0;
			word_q      <= '0;
			bit_q       <= '0;
		end else begin
			if (rsp_set) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				ST_FILL: begin
					wcnt_q <= wcnt_inc;
					if (wcnt_q == LAST_W) begin
						sel_q   <= '0;
						state_q <= (cmd_q == fbba_pkg::CMD_INIT) ? ST_RSV : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (req_take) begin
						cmd_q <= fbba_pkg::cmd_t'(cmd);
						case (fbba_pkg::cmd_t'(cmd))
							fbba_pkg::CMD_INIT: begin
								wcnt_q  <= '0;
								state_q <= ST_FILL;
							end
							fbba_pkg::CMD_FIND: begin
								pend_s1 <= '0;
								wcnt_q  <= scan_start;
								state_q <= ST_SCAN;
							end
							default: begin
								if (blk_ok) begin
									state_q <= ST_FIX;
								end else begin
									found_q     <= 1'b0;
									fblk_q      <= '0;
									status_q    <= 1'b1;
								end
							end
						endcase
					end
				end
				ST_RSV: begin
					if (rsv_ok) begin
						state_q <= ST_FIX;
					end else if (sel_q == 2'd3) begin
						count_q     <= init_count;
						found_q     <= 1'b0;
						fblk_q      <= '0;
						status_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						sel_q <= sel_q + 2'd1;
					end
				end
				ST_FIX: begin
					word_q  <= AW'(quo);
					bit_q   <= rem;
					state_q <= ST_RMW;
				end
				ST_RMW: begin
					if ((cmd_q == fbba_pkg::CMD_INIT) && (sel_q != 2'd3)) begin
						sel_q   <= sel_q + 2'd1;
						state_q <= ST_RSV;
					end else begin
						if (cmd_q == fbba_pkg::CMD_INIT) begin
							count_q <= init_count;
						end else if (cmd_q == fbba_pkg::CMD_RELEASE) begin
							count_q <= count_inc;
						end
						found_q     <= 1'b0;
						fblk_q      <= '0;
						status_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end
				end
				ST_SCAN: begin
					if (wu_hit || (pend_s1 == LAST_W)) begin
						found_q     <= wu_hit;
						fblk_q      <= wu_hit ? find_idx[fbba_pkg::FREE_BLOCK_W-1:0] : '0;
						status_q    <= 1'b0;
						state_q     <= ST_IDLE;
					end else begin
						pend_s1 <= wcnt_q;
						wcnt_q  <= wcnt_inc;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Result outputs; the count holds until an init or a release updates it.
	assign rsp_valid  = rsp_valid_q;
	assign found      = found_q;
	assign free_block = fblk_q;
	assign free_total = fbba_pkg::FREE_TOTAL_W'(count_q);
	assign status     = status_q;

	// The free count never passes the block total.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= 32'(NUM_BLOCKS))
		else $error("free count exceeds block total");

	// The scan never evaluates a word ahead of the one issued to the RAM.
	a_scan_order: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (pend_s1 <= wcnt_q))
		else $error("scan data word ahead of read address");

	// A found block always comes with an ok status.
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && found) |-> !status)
		else $error("found result flagged out of range");

	// A release never lowers the free count.
	a_release_up: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_RMW) && (cmd_q == fbba_pkg::CMD_RELEASE)) |=>
		(count_q >= $past(count_q)))
		else $error("release decreased the free count");

endmodule

`default_nettype wire
